FILE: hw/rtl/scmips_pkg.sv
// ----------------------------------------------------------------------------
// scmips_pkg
// Shared types and constants of the single-cycle MIPS subset core: command,
// opcode and status codes, item and result layouts, internal write bundles.
// ----------------------------------------------------------------------------
package scmips_pkg;

	localparam int WORD_W    = 32;
	localparam int REG_COUNT = 32;
	localparam int REG_AW    = 5;

	// Commands carried by an input item
	localparam logic [1:0] CMD_EXEC     = 2'd0;
	localparam logic [1:0] CMD_LOAD_REG = 2'd1;
	localparam logic [1:0] CMD_LOAD_MEM = 2'd2;

	// Opcodes of the supported subset
	localparam logic [5:0] OP_ADD = 6'd0;
	localparam logic [5:0] OP_J   = 6'd2;
	localparam logic [5:0] OP_BEQ = 6'd4;
	localparam logic [5:0] OP_LW  = 6'd35;
	localparam logic [5:0] OP_SW  = 6'd43;

	// Result status codes
	localparam logic [1:0] ST_OK     = 2'd0;
	localparam logic [1:0] ST_BAD_OP = 2'd1;
	localparam logic [1:0] ST_RANGE  = 2'd2;

	// Configuration register index (word index on the APB port)
	localparam logic REG_END_ADDRESS = 1'b0;
	localparam logic [WORD_W-1:0] END_ADDRESS_RST = 32'd64;

	typedef struct packed {
		logic [1:0]        command;
		logic [WORD_W-1:0] instruction;
		logic [5:0]        load_index;
		logic [WORD_W-1:0] load_value;
	} item_t;

	typedef struct packed {
		logic [WORD_W-1:0] next_pc;
		logic              reg_write;
		logic [4:0]        dest_reg;
		logic [WORD_W-1:0] reg_value;
		logic              mem_write;
		logic [5:0]        mem_address;
		logic [WORD_W-1:0] mem_value;
		logic              branch_taken;
		logic [1:0]        status;
		logic              finished;
	} result_t;

	// Register file write port
	typedef struct packed {
		logic              we;
		logic [REG_AW-1:0] idx;
		logic [WORD_W-1:0] data;
	} rf_wr_t;

	// Outcome of executing one item
	typedef struct packed {
		result_t           res;
		logic              lw_hit;   // in-range load, data comes from the store
		logic              rf_we;
		logic [REG_AW-1:0] rf_idx;
		logic [WORD_W-1:0] rf_val;
		logic              mem_we;
		logic [WORD_W-1:0] mem_wdata;
	} exec_t;

endpackage

FILE: hw/rtl/scmips_regfile.sv
// ----------------------------------------------------------------------------
// scmips_regfile
// 32 x 32 register file: one write port, two registered read ports with
// write-first bypass. Per-entry valid bits give the all-zero reset image.
// ----------------------------------------------------------------------------
module scmips_regfile import scmips_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              rd_en,
	input  logic [REG_AW-1:0] rd_idx_a,
	input  logic [REG_AW-1:0] rd_idx_b,
	input  rf_wr_t            wr,
	output logic [WORD_W-1:0] rd_data_a,
	output logic [WORD_W-1:0] rd_data_b
);

	logic [WORD_W-1:0]    mem_q [REG_COUNT];
	logic [REG_COUNT-1:0] vld_q;
	logic [WORD_W-1:0]    rda_q, rdb_q;
	logic [WORD_W-1:0]    rda_next, rdb_next;

	// Storage write
	always_ff @(posedge clk) begin
		if (wr.we) begin
			mem_q[wr.idx] <= wr.data;
		end
	end

	// Entry valid bits: unwritten entries read as zero
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (wr.we) begin
			vld_q[wr.idx] <= 1'b1;
		end
	end

	// Read with bypass of a write at the same edge
	always_comb begin
		rda_next = vld_q[rd_idx_a] ? mem_q[rd_idx_a] : '0;
		rdb_next = vld_q[rd_idx_b] ? mem_q[rd_idx_b] : '0;
		if (wr.we && (wr.idx == rd_idx_a)) begin
			rda_next = wr.data;
		end
		if (wr.we && (wr.idx == rd_idx_b)) begin
			rdb_next = wr.data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rda_q <= rda_next;
			rdb_q <= rdb_next;
		end
	end

	assign rd_data_a = rda_q;
	assign rd_data_b = rdb_q;

endmodule

FILE: hw/rtl/scmips_dmem.sv
// ----------------------------------------------------------------------------
// scmips_dmem
// Data store: one write port, one registered read port. After reset a
// clearing pass zeroes every word, one per cycle, while busy is high.
// ----------------------------------------------------------------------------
module scmips_dmem import scmips_pkg::*; #(
	parameter int MEM_WORDS = 64
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         rd_en,
	input  logic [$clog2(MEM_WORDS)-1:0] rd_idx,
	input  logic                         wr_en,
	input  logic [$clog2(MEM_WORDS)-1:0] wr_idx,
	input  logic [WORD_W-1:0]            wr_data,
	output logic [WORD_W-1:0]            rd_data,
	output logic                         busy
);

	localparam int AW = $clog2(MEM_WORDS);

	logic [WORD_W-1:0] mem_q [MEM_WORDS];
	logic [WORD_W-1:0] rd_q;
	logic              busy_q;
	logic [AW-1:0]     clr_idx_q;

	// Clearing pass sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q    <= 1'b1;
			clr_idx_q <= '0;
		end else if (busy_q) begin
			clr_idx_q <= clr_idx_q + 1'b1;
			if (clr_idx_q == AW'(MEM_WORDS - 1)) begin
				busy_q <= 1'b0;
			end
		end
	end

	// Write port, shared with the clearing pass
	always_ff @(posedge clk) begin
		if (busy_q) begin
			mem_q[clr_idx_q] <= '0;
		end else if (wr_en) begin
			mem_q[wr_idx] <= wr_data;
		end
	end

	// Registered read
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_q <= mem_q[rd_idx];
		end
	end

	assign rd_data = rd_q;
	assign busy    = busy_q;

endmodule

FILE: hw/rtl/scmips_exec.sv
// ----------------------------------------------------------------------------
// scmips_exec
// Decode and execute of one item: next pc, branch, add, load/store address
// and range check, preloads, status and end-of-program compare.
// ----------------------------------------------------------------------------
module scmips_exec import scmips_pkg::*; #(
	parameter int MEM_WORDS = 64
) (
	input  item_t                        item,
	input  logic [WORD_W-1:0]            pc,
	input  logic [WORD_W-1:0]            rs_val,
	input  logic [WORD_W-1:0]            rt_val,
	input  logic [WORD_W-1:0]            end_address,
	output exec_t                        ex,
	output logic [$clog2(MEM_WORDS)-1:0] mem_idx
);

	localparam int AW = $clog2(MEM_WORDS);

	logic [5:0]        op;
	logic [REG_AW-1:0] rt_idx, rd_idx;
	logic [WORD_W-1:0] imm, pc4, addr, ld_ext;
	logic              addr_ok, ld_ok;

	// Field extraction and shared arithmetic
	always_comb begin
		op      = item.instruction[31:26];
		rt_idx  = item.instruction[20:16];
		rd_idx  = item.instruction[15:11];
		imm     = {{16{item.instruction[15]}}, item.instruction[15:0]};
		pc4     = pc + 32'd4;
		addr    = rs_val + imm;
		ld_ext  = {26'd0, item.load_index};
		addr_ok = addr < 32'(MEM_WORDS);
		ld_ok   = ld_ext < 32'(MEM_WORDS);
	end

	// Command and opcode decode
	always_comb begin
		ex             = '0;
		ex.res.next_pc = pc;
		mem_idx        = addr[AW-1:0];
		unique case (item.command)
			CMD_EXEC: begin
				ex.res.next_pc = pc4;
				unique case (op) inside
					OP_ADD: begin
						if (rd_idx != '0) begin
							ex.rf_we            = 1'b1;
							ex.rf_idx           = rd_idx;
							ex.rf_val           = rs_val + rt_val;
							ex.res.reg_write    = 1'b1;
							ex.res.dest_reg     = rd_idx;
							ex.res.reg_value    = rs_val + rt_val;
						end
					end
					OP_J: begin
						ex.res.next_pc      = {pc4[31:28], item.instruction[25:0], 2'b00};
						ex.res.branch_taken = 1'b1;
					end
					OP_BEQ: begin
						if (rs_val == rt_val) begin
							ex.res.next_pc      = pc4 + {imm[29:0], 2'b00};
							ex.res.branch_taken = 1'b1;
						end
					end
					OP_LW, OP_SW: begin
						if (!addr_ok) begin
							ex.res.status = ST_RANGE;
						end else if (op == OP_LW) begin
							// value filled in from the store in the result stage
							ex.lw_hit          = 1'b1;
							ex.res.mem_address = addr[5:0];
							if (rt_idx != '0) begin
								ex.rf_we         = 1'b1;
								ex.rf_idx        = rt_idx;
								ex.res.reg_write = 1'b1;
								ex.res.dest_reg  = rt_idx;
							end
						end else begin
							ex.mem_we          = 1'b1;
							ex.mem_wdata       = rt_val;
							ex.res.mem_write   = 1'b1;
							ex.res.mem_address = addr[5:0];
							ex.res.mem_value   = rt_val;
						end
					end
					default: begin
						ex.res.status = ST_BAD_OP;
					end
				endcase
			end
			CMD_LOAD_REG: begin
				// silent write: no result fields
				if (!item.load_index[5] && (item.load_index[4:0] != '0)) begin
					ex.rf_we  = 1'b1;
					ex.rf_idx = item.load_index[4:0];
					ex.rf_val = item.load_value;
				end
			end
			CMD_LOAD_MEM: begin
				mem_idx = ld_ext[AW-1:0];
				if (ld_ok) begin
					ex.mem_we    = 1'b1;
					ex.mem_wdata = item.load_value;
				end else begin
					ex.res.status = ST_RANGE;
				end
			end
			default: begin
				ex.res.status = ST_BAD_OP;
			end
		endcase
		ex.res.finished = ex.res.next_pc >= end_address;
	end

endmodule

FILE: hw/rtl/single_cycle_mips_subset_core.sv
// Stages: an accepted item is registered in the input stage, then in the result stage.
// Throughput: one item per cycle when nothing stalls; the store's registered read port sets the two stages.
// Register operands come from the result stage by forwarding, so dependent items run back to back.
// Reset: pc = 0, end_address = 64, register file zero through valid bits; the data store is
// cleared after reset by a pass over all MEM_WORDS words, during which item_stall stays high.
// ----------------------------------------------------------------------------
// single_cycle_mips_subset_core
// MIPS subset datapath (add, j, beq, lw, sw) with register and store preload
// commands, an APB register for the end address and a registered result stage.
// ----------------------------------------------------------------------------
module single_cycle_mips_subset_core import scmips_pkg::*; #(
	parameter int MEM_WORDS = 64
) (
	input  logic              clk,
	input  logic              arst_n,
	// input items
	input  logic              item_valid,
	output logic              item_stall,
	input  item_t             item,
	// results
	output logic              result_valid,
	input  logic              result_stall,
	output result_t           result,
	// configuration
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [2:0]        paddr,
	input  logic [WORD_W-1:0] pwdata,
	output logic [WORD_W-1:0] prdata,
	output logic              pready
);

	localparam int AW = $clog2(MEM_WORDS);

	logic [WORD_W-1:0] end_address_q;
	logic [WORD_W-1:0] pc_q;

	logic              vld_s1, vld_s2;
	item_t             item_s1;
	exec_t             ex_s2;

	logic              adv_s2, take_s1, go_s1, item_acc;
	logic [WORD_W-1:0] rs_rd, rt_rd, rs_val, rt_val;
	exec_t             ex;
	logic [AW-1:0]     mem_idx;
	logic [WORD_W-1:0] dmem_rdata;
	logic              dmem_busy;
	rf_wr_t            wr_s2, rf_wr;
	result_t           res_out;

	// Configuration port
	assign pready = 1'b1;
	assign prdata = (paddr[2] == REG_END_ADDRESS) ? end_address_q : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			end_address_q <= END_ADDRESS_RST;
		end else if (psel && penable && pwrite && pready && (paddr[2] == REG_END_ADDRESS)) begin
			end_address_q <= pwdata;
		end
	end

	// Stage flow control
	assign adv_s2     = !vld_s2 || !result_stall;
	assign take_s1    = !vld_s1 || adv_s2;
	assign go_s1      = vld_s1 && adv_s2;
	assign item_stall = dmem_busy || !take_s1;
	assign item_acc   = item_valid && !item_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
		end else begin
			if (take_s1) begin
				vld_s1 <= item_acc;
			end
			if (adv_s2) begin
				vld_s2 <= vld_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (item_acc) begin
			item_s1 <= item;
		end
		if (go_s1) begin
			ex_s2 <= ex;
		end
	end

	// Program counter advances as an item leaves the input stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q <= '0;
		end else if (go_s1) begin
			pc_q <= ex.res.next_pc;
		end
	end

	// Pending register write of the item in the result stage
	always_comb begin
		wr_s2.we   = vld_s2 && ex_s2.rf_we;
		wr_s2.idx  = ex_s2.rf_idx;
		wr_s2.data = ex_s2.lw_hit ? dmem_rdata : ex_s2.rf_val;
		rf_wr      = wr_s2;
		rf_wr.we   = wr_s2.we && !result_stall;
	end

	scmips_regfile u_regfile (
		.clk       (clk),
		.arst_n    (arst_n),
		.rd_en     (item_acc),
		.rd_idx_a  (item.instruction[25:21]),
		.rd_idx_b  (item.instruction[20:16]),
		.wr        (rf_wr),
		.rd_data_a (rs_rd),
		.rd_data_b (rt_rd)
	);

	// Operand forwarding from the result stage
	always_comb begin
		rs_val = rs_rd;
		rt_val = rt_rd;
		if (wr_s2.we && (wr_s2.idx == item_s1.instruction[25:21])) begin
			rs_val = wr_s2.data;
		end
		if (wr_s2.we && (wr_s2.idx == item_s1.instruction[20:16])) begin
			rt_val = wr_s2.data;
		end
	end

	scmips_exec #(
		.MEM_WORDS (MEM_WORDS)
	) u_exec (
		.item        (item_s1),
		.pc          (pc_q),
		.rs_val      (rs_val),
		.rt_val      (rt_val),
		.end_address (end_address_q),
		.ex          (ex),
		.mem_idx     (mem_idx)
	);

	scmips_dmem #(
		.MEM_WORDS (MEM_WORDS)
	) u_dmem (
		.clk     (clk),
		.arst_n  (arst_n),
		.rd_en   (go_s1 && ex.lw_hit),
		.rd_idx  (mem_idx),
		.wr_en   (go_s1 && ex.mem_we),
		.wr_idx  (mem_idx),
		.wr_data (ex.mem_wdata),
		.rd_data (dmem_rdata),
		.busy    (dmem_busy)
	);

	// Result: loaded word merged in from the store's read register
	always_comb begin
		res_out = ex_s2.res;
		if (ex_s2.lw_hit) begin
			res_out.mem_value = dmem_rdata;
			if (ex_s2.res.reg_write) begin
				res_out.reg_value = dmem_rdata;
			end
		end
	end

	assign result_valid = vld_s2;
	assign result       = res_out;

	// Checks
	a_no_reg0_write: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> !(result.reg_write && (result.dest_reg == '0)))
		else $error("register zero reported as written");

	a_one_write_kind: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> !(result.reg_write && result.mem_write))
		else $error("register and store written by one item");

	a_status_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && (result.status != ST_OK))
		|-> (!result.reg_write && !result.mem_write && !result.branch_taken))
		else $error("flagged item has side effects");

	a_pc_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!go_s1 |=> $stable(pc_q))
		else $error("pc moved without an item leaving the input stage");

	a_clear_empty: assert property (@(posedge clk) disable iff (!arst_n)
		dmem_busy |-> (!vld_s1 && !vld_s2))
		else $error("item in flight during store clearing pass");

endmodule
